// ===== rtl/btc_pkg.sv =====
// Package for the block transposition cipher: widths, register codes,
// configuration and block queue types, key nibble and length helpers.
// No dependencies.
`timescale 1ns / 1ps

package btc_pkg;

	localparam int BLOCK_MAX = 16;
	localparam int IDX_W     = $clog2(BLOCK_MAX);
	localparam int LEN_W     = 5;
	localparam int KEY_W     = 64;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 5;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0]       PAD_BYTE  = 8'h60;
	localparam logic [LEN_W-1:0] LEN_RST   = LEN_W'(BLOCK_MAX);
	localparam logic [KEY_W-1:0] KEY_RST   = 64'hFEDCBA9876543210;

	typedef enum logic [1:0] {
		REG_LEN  = 2'd0,
		REG_KEY  = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] blk_len;
		logic [KEY_W-1:0] key;
		logic             dec;
	} cfg_t;

	// one closed block; len 0 marks an end marker with no bytes
	typedef struct packed {
		logic [BLOCK_MAX-1:0][7:0] data;
		logic [LEN_W-1:0]          len;
		logic                      dec;
		logic                      eom;
		logic                      err;
	} blk_t;

	function automatic logic [IDX_W-1:0] key_nib(input logic [KEY_W-1:0] key,
		input logic [IDX_W-1:0] pos);
		return key[4*pos +: 4];
	endfunction

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = len;
		if (len == '0) r = LEN_W'(1);
		if (len > LEN_W'(BLOCK_MAX)) r = LEN_W'(BLOCK_MAX);
		return r;
	endfunction

endpackage

// ===== rtl/btc_in_if.sv =====
// Message byte channel: valid/ready with the input payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface btc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_message;

	modport source (output valid, output in_byte, output end_of_message, input ready);
	modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== rtl/btc_out_if.sv =====
// Result channel: valid/ready with the output payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface btc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       data_present;
	logic       last_of_message;
	logic       length_error;

	modport source (output valid, output out_byte, output data_present,
		output last_of_message, output length_error, input ready);
	modport sink   (input valid, input out_byte, input data_present,
		input last_of_message, input length_error, output ready);
endinterface

// ===== rtl/btc_regs.sv =====
// APB-style configuration registers: block length, key, mode.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btc_pkg::ADDR_W-1:0]    paddr,
	input  logic [btc_pkg::DATA_W-1:0]    pwdata,
	output logic [btc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output btc_pkg::cfg_t                 cfg
);
	import btc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blk_len <= LEN_RST;
			cfg_q.key     <= KEY_RST;
			cfg_q.dec     <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_LEN:  cfg_q.blk_len <= pwdata[LEN_W-1:0];
				REG_KEY:  cfg_q.key     <= pwdata[KEY_W-1:0];
				REG_MODE: cfg_q.dec     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LEN:  prdata = DATA_W'(cfg_q.blk_len);
			REG_KEY:  prdata = DATA_W'(cfg_q.key);
			REG_MODE: prdata = DATA_W'(cfg_q.dec);
			default:  prdata = '0;
		endcase
	end
endmodule

// ===== rtl/btc_front.sv =====
// Front end: takes message bytes, builds the block buffer (scatter and
// padding for encrypt, plain fill for decrypt) and pushes closed blocks.
// Depends on btc_pkg and btc_in_if.
`timescale 1ns / 1ps

module btc_front (
	input  logic          clk,
	input  logic          arst_n,
	btc_in_if.sink        msg,
	input  btc_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          push,
	output btc_pkg::blk_t push_blk
);
	import btc_pkg::*;

	logic [BLOCK_MAX-1:0][7:0] buf_q;
	logic [BLOCK_MAX-1:0][7:0] new_buf;
	logic [LEN_W-1:0]          fill_q;
	logic [LEN_W-1:0]          len;
	logic [LEN_W-1:0]          filled;
	logic [IDX_W-1:0]          pos;
	logic [IDX_W-1:0]          kpos;
	logic                      full;
	logic                      eom;
	logic                      closing;
	logic                      acc;
	logic [BLOCK_MAX-1:0]      pad_hit;

	assign msg.ready = !q_full;
	assign acc       = msg.valid && msg.ready;

	always_comb begin
		len     = eff_len(cfg.blk_len);
		pos     = fill_q[IDX_W-1:0];
		filled  = fill_q + LEN_W'(1);
		full    = filled >= len;
		eom     = msg.end_of_message;
		closing = full || eom;
		kpos    = key_nib(cfg.key, pos);
		for (int j = 0; j < BLOCK_MAX; j++) begin
			pad_hit[j] = 1'b0;
			for (int k = 0; k < BLOCK_MAX; k++) begin
				if (eom && LEN_W'(k) >= filled && LEN_W'(k) < len &&
					key_nib(cfg.key, IDX_W'(k)) == IDX_W'(j))
					pad_hit[j] = 1'b1;
			end
		end
		for (int j = 0; j < BLOCK_MAX; j++) begin
			if (cfg.dec)
				new_buf[j] = (pos == IDX_W'(j)) ? msg.in_byte : buf_q[j];
			else if (pad_hit[j])
				new_buf[j] = PAD_BYTE;
			else
				new_buf[j] = (kpos == IDX_W'(j)) ? msg.in_byte : buf_q[j];
		end
		push          = acc && closing;
		push_blk.data = new_buf;
		push_blk.len  = (cfg.dec && !full) ? '0 : len;
		push_blk.dec  = cfg.dec;
		push_blk.eom  = eom;
		push_blk.err  = cfg.dec && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			fill_q <= closing ? '0 : filled;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) buf_q <= new_buf;
	end
endmodule

// ===== rtl/btc_queue.sv =====
// Two-entry queue of closed blocks between front and back end.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  btc_pkg::blk_t              push_blk,
	input  logic                       pop,
	output btc_pkg::blk_t              head,
	output logic                       full,
	output logic                       have,
	output logic [btc_pkg::QCNT_W-1:0] count
);
	import btc_pkg::*;

	blk_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign have  = cnt_q != '0;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_blk;
	end
endmodule

// ===== rtl/btc_back.sv =====
// Back end: walks the head block one position a cycle when the output is
// free (gather for decrypt), trims at the pad in a final decrypt block,
// drives the output register. Depends on btc_pkg and btc_out_if.
`timescale 1ns / 1ps

module btc_back (
	input  logic          clk,
	input  logic          arst_n,
	btc_out_if.source     res,
	input  btc_pkg::cfg_t cfg,
	input  btc_pkg::blk_t head,
	input  logic          have,
	output logic          pop
);
	import btc_pkg::*;

	logic [LEN_W-1:0] idx_q;
	logic             hold_v_q;
	logic [7:0]       hold_q;
	logic             ov_q;
	logic [7:0]       obyte_q;
	logic             opres_q;
	logic             olast_q;
	logic             oerr_q;

	logic [IDX_W-1:0] sel;
	logic [7:0]       b;
	logic             reading;
	logic             out_free;
	logic             step;
	logic             emit;
	logic [7:0]       e_byte;
	logic             e_pres;
	logic             e_last;
	logic             e_err;

	assign out_free = !ov_q || res.ready;

	always_comb begin
		sel     = head.dec ? key_nib(cfg.key, idx_q[IDX_W-1:0]) : idx_q[IDX_W-1:0];
		b       = head.data[sel];
		reading = have && idx_q < head.len && !(head.dec && head.eom && b == PAD_BYTE);
		step    = have && out_free;
		emit    = 1'b0;
		e_byte  = 8'd0;
		e_pres  = 1'b0;
		e_last  = 1'b0;
		e_err   = 1'b0;
		if (step) begin
			if (hold_v_q) begin
				emit   = 1'b1;
				e_byte = hold_q;
				e_pres = 1'b1;
				e_last = head.eom && !reading;
			end else if (!reading && head.eom) begin
				emit   = 1'b1;
				e_last = 1'b1;
				e_err  = head.err;
			end
		end
		pop = step && !reading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (step) begin
				hold_v_q <= reading;
				idx_q    <= reading ? idx_q + LEN_W'(1) : '0;
			end
			if (out_free) ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && reading) hold_q <= b;
		if (out_free && emit) begin
			obyte_q <= e_byte;
			opres_q <= e_pres;
			olast_q <= e_last;
			oerr_q  <= e_err;
		end
	end

	assign res.valid           = ov_q;
	assign res.out_byte        = obyte_q;
	assign res.data_present    = opres_q;
	assign res.last_of_message = olast_q;
	assign res.length_error    = oerr_q;
endmodule

// ===== rtl/block_transposition_cipher_top.sv =====
// Top level of the block transposition cipher: registers, front end,
// block queue, back end. Depends on btc_pkg, btc_in_if, btc_out_if and all btc modules.
//
//   channel  kind       payload
//   msg      sink       in_byte[7:0], end_of_message
//   res      source     out_byte[7:0], data_present, last_of_message, length_error
//   apb      slave      paddr[4:0], pwdata/prdata[63:0], registers at 8*i
//
// One byte is accepted per cycle while the two-block queue has room.
// The back end walks one block position per cycle while the output is free;
// the first result of a block passes the queue entry, the hold register and
// the output register, a lone end marker only the queue entry and the output
// register. Reset clears fill count, queue and output valid; the buffers need
// no clearing. A stalled output fills the queue, then drops msg.ready.
`timescale 1ns / 1ps

module block_transposition_cipher_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [btc_pkg::ADDR_W-1:0] paddr,
	input  logic [btc_pkg::DATA_W-1:0] pwdata,
	output logic [btc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	btc_in_if.sink                     msg,
	btc_out_if.source                  res
);
	import btc_pkg::*;

	cfg_t              cfg;
	blk_t              push_blk;
	blk_t              head;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              have;
	logic [QCNT_W-1:0] q_count;

	btc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	btc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_blk (push_blk)
	);

	btc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_blk (push_blk),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.have     (have),
		.count    (q_count)
	);

	btc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.cfg    (cfg),
		.head   (head),
		.have   (have),
		.pop    (pop)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < QCNT_W'(QDEPTH) || pop))
		else $error("block pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("block popped from an empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_count == $past(q_count) + QCNT_W'(1))
		else $error("queue count lost a push");
endmodule

// ===== verif/block_transposition_cipher_top_tb.sv =====
// Self-checking testbench for block_transposition_cipher_top: directed table, then random
// phases of messages under random key/length/mode, checked against an in-bench cipher model.
// Depends on btc_pkg, btc_in_if, btc_out_if and the cipher RTL.
`timescale 1ns / 1ps

module block_transposition_cipher_top_tb;
	import btc_pkg::*;

	localparam int TOTAL_ITEMS = 210;
	localparam int SETTLE_CYC  = 10;
	localparam int DRAIN_CYC   = 20;
	localparam int LIMIT_CYC   = 400000;
	localparam int HOLD_CYC    = 80;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       is_last;
		logic       err;
	} res_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [63:0] val;
		logic [7:0]  data;
		logic        eom;
		logic        typed;
		res_t        want;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	btc_in_if  msg_if ();
	btc_out_if res_if ();

	block_transposition_cipher_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.msg     (msg_if),
		.res     (res_if)
	);

	// cipher model state
	logic [LEN_W-1:0] len_reg;
	logic [KEY_W-1:0] key_reg;
	logic             dec_reg;
	logic [7:0]       blk_buf [BLOCK_MAX];
	int               fill;

	res_t cipher_q [$];
	row_t stim_rows [$];
	int   n_items = 0;
	int   bad_cnt = 0;
	bit   src_quiet = 1'b0;
	bit   sink_quiet = 1'b0;
	bit   hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int blk_len_now();
		int l;
		l = int'(len_reg);
		if (l < 1) l = 1;
		if (l > BLOCK_MAX) l = BLOCK_MAX;
		return l;
	endfunction

	function automatic int slot_of(int k);
		return int'(key_reg[4*(k%16) +: 4]);
	endfunction

	function automatic res_t mk_res(logic [7:0] d, logic p, logic l, logic e);
		res_t r;
		r.data = d;
		r.present = p;
		r.is_last = l;
		r.err = e;
		return r;
	endfunction

	task automatic cipher_step(input logic [7:0] b, input logic eom);
		int   l, pos, filled, n;
		bit   full;
		logic [7:0] v;
		l = blk_len_now();
		pos = fill % 16;
		filled = fill + 1;
		full = filled >= l;
		n = 0;
		if (!dec_reg) begin
			blk_buf[slot_of(pos)] = b;
			if (!full && !eom) begin
				fill = filled;
				return;
			end
			for (int k = filled; k < l; k++) blk_buf[slot_of(k)] = PAD_BYTE;
			for (int k = 0; k < l; k++)
				cipher_q.push_back(mk_res(blk_buf[k], 1'b1, eom && (k == l - 1), 1'b0));
			fill = 0;
			return;
		end
		blk_buf[pos] = b;
		if (!full) begin
			if (eom) begin
				cipher_q.push_back(mk_res(8'h00, 1'b0, 1'b1, 1'b1));
				fill = 0;
			end else begin
				fill = filled;
			end
			return;
		end
		fill = 0;
		for (int k = 0; k < l; k++) begin
			v = blk_buf[slot_of(k)];
			if (eom && v == PAD_BYTE) break;
			cipher_q.push_back(mk_res(v, 1'b1, 1'b0, 1'b0));
			n++;
		end
		if (eom) begin
			if (n == 0) cipher_q.push_back(mk_res(8'h00, 1'b0, 1'b1, 1'b0));
			else cipher_q[$].is_last = 1'b1;
		end
	endtask

	function automatic row_t cfg_row(reg_idx_t i, logic [63:0] v);
		row_t r;
		r.kind = ROW_CFG;
		r.idx = i;
		r.val = v;
		r.data = '0;
		r.eom = 1'b0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t byte_row(logic [7:0] b, logic e, logic t = 1'b0, res_t w = '0);
		row_t r;
		r.kind = ROW_BYTE;
		r.idx = REG_LEN;
		r.val = '0;
		r.data = b;
		r.eom = e;
		r.typed = t;
		r.want = w;
		return r;
	endfunction

	function automatic logic [63:0] pick_key(int l);
		logic [63:0] k;
		int          perm [BLOCK_MAX];
		int          j, t, r;
		r = $urandom_range(0, 7);
		k = {$urandom, $urandom};
		if (r == 0) return '0;
		if (r == 1) return '1;
		if (r == 2) return k;
		for (int i = 0; i < l; i++) perm[i] = i;
		for (int i = l - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < l; i++) k[4*i +: 4] = 4'(perm[i]);
		return k;
	endfunction

	function automatic int src_gap();
		int r;
		if (src_quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'(8 * int'(idx));
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LEN:  len_reg = v[LEN_W-1:0];
			REG_KEY:  key_reg = v;
			REG_MODE: dec_reg = v[0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e, input logic typed, input res_t w);
		int gap, n0;
		gap = src_gap();
		if (gap > 0) begin
			msg_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_if.valid = 1'b1;
		msg_if.in_byte = b;
		msg_if.end_of_message = e;
		do @(posedge clk); while (!msg_if.ready);
		n0 = cipher_q.size();
		cipher_step(b, e);
		if (typed) begin
			while (cipher_q.size() > n0) void'(cipher_q.pop_back());
			cipher_q.push_back(w);
		end
		n_items++;
		@(negedge clk);
	endtask

	// quiesce: no transfer offered, all results in, then let the pipeline settle
	task automatic settle(input int extra);
		msg_if.valid = 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = {res_if.out_byte, res_if.data_present, res_if.last_of_message,
				res_if.length_error};
			if (cipher_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= REPORT_MAX)
					$display("unexpected result: byte %02h present %b last %b err %b",
						got.data, got.present, got.is_last, got.err);
			end else begin
				want = cipher_q.pop_front();
				if (got !== want) begin
					bad_cnt++;
					if (bad_cnt <= REPORT_MAX)
						$display("mismatch: exp %02h/%b/%b/%b got %02h/%b/%b/%b",
							want.data, want.present, want.is_last, want.err,
							got.data, got.present, got.is_last, got.err);
				end
			end
		end
	end

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap_left, r;
		gap_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				gap_left = HOLD_CYC;
			end
			if (gap_left > 0) begin
				res_if.ready = 1'b0;
				gap_left--;
			end else if (sink_quiet) begin
				res_if.ready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) gap_left = $urandom_range(1, 3);
				else if (r < 18) gap_left = $urandom_range(10, 30);
				res_if.ready = (gap_left == 0);
			end
		end
	end

	initial begin
		repeat (LIMIT_CYC) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0]  first_blk [16];
		logic [63:0] kv;
		logic [7:0]  b;
		int          phase, nmsg, mlen, l, lv;
		bit          squeeze, cut;
		first_blk = '{8'h00, 8'hFF, 8'h60, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55,
			8'hFE, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h60};
		msg_if.valid = 1'b0;
		msg_if.in_byte = '0;
		msg_if.end_of_message = 1'b0;
		len_reg = LEN_RST;
		key_reg = KEY_RST;
		dec_reg = 1'b0;
		fill = 0;
		foreach (blk_buf[i]) blk_buf[i] = '0;

		// full block at reset settings writes every buffer slot
		for (int i = 0; i < 16; i++) stim_rows.push_back(byte_row(first_blk[i], i == 15));
		stim_rows.push_back(cfg_row(REG_LEN, 64'd31));
		stim_rows.push_back(byte_row(8'hC3, 1'b1));
		stim_rows.push_back(cfg_row(REG_LEN, 64'd0));
		stim_rows.push_back(byte_row(8'hA5, 1'b0, 1'b1, mk_res(8'hA5, 1'b1, 1'b0, 1'b0)));
		stim_rows.push_back(cfg_row(REG_MODE, 64'd1));
		stim_rows.push_back(byte_row(PAD_BYTE, 1'b1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b0)));
		stim_rows.push_back(cfg_row(REG_LEN, 64'd2));
		stim_rows.push_back(cfg_row(REG_KEY, 64'hFEDC_BA98_7654_3201));
		stim_rows.push_back(byte_row(8'h11, 1'b0));
		stim_rows.push_back(byte_row(8'h22, 1'b0));
		stim_rows.push_back(byte_row(8'h33, 1'b1, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b1)));
		// length and mode changed with two bytes held
		stim_rows.push_back(cfg_row(REG_LEN, 64'd4));
		stim_rows.push_back(cfg_row(REG_MODE, 64'd0));
		stim_rows.push_back(byte_row(8'hAA, 1'b0));
		stim_rows.push_back(byte_row(8'hBB, 1'b0));
		stim_rows.push_back(cfg_row(REG_LEN, 64'd2));
		stim_rows.push_back(cfg_row(REG_MODE, 64'd1));
		stim_rows.push_back(byte_row(8'hCC, 1'b1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				settle(SETTLE_CYC);
				write_reg(stim_rows[i].idx, stim_rows[i].val);
			end else begin
				send_byte(stim_rows[i].data, stim_rows[i].eom, stim_rows[i].typed,
					stim_rows[i].want);
			end
		end

		phase = 0;
		while (n_items < TOTAL_ITEMS) begin
			squeeze = (phase == 1);
			settle(SETTLE_CYC);
			case ($urandom_range(0, 19))
				0: lv = 0;
				1: lv = $urandom_range(17, 31);
				2: lv = 16;
				3: lv = 1;
				default: lv = $urandom_range(2, 8);
			endcase
			if (squeeze) lv = 4;
			write_reg(REG_LEN, 64'(lv));
			l = blk_len_now();
			kv = pick_key(l);
			write_reg(REG_KEY, kv);
			write_reg(REG_MODE, squeeze ? 64'd0 : 64'($urandom_range(0, 1)));
			src_quiet = squeeze || ($urandom_range(0, 4) == 0);
			sink_quiet = !squeeze && ($urandom_range(0, 4) == 0);
			if (squeeze) hold_req = 1'b1;
			nmsg = squeeze ? 1 : $urandom_range(1, 3);
			cut = !squeeze && ($urandom_range(0, 4) == 0);
			for (int m = 0; m < nmsg; m++) begin
				if (n_items >= TOTAL_ITEMS) break;
				if (squeeze) mlen = 48;
				else if (dec_reg && $urandom_range(0, 4) != 0) mlen = l * $urandom_range(1, 3);
				else mlen = $urandom_range(1, 2 * l + 2);
				if (!squeeze && mlen > TOTAL_ITEMS - n_items) mlen = TOTAL_ITEMS - n_items;
				for (int j = 0; j < mlen; j++) begin
					b = ($urandom_range(0, 5) == 0) ? PAD_BYTE : 8'($urandom);
					send_byte(b, (j == mlen - 1) && !(cut && m == nmsg - 1), 1'b0, '0);
				end
			end
			phase++;
		end

		settle(DRAIN_CYC);
		if (bad_cnt == 0 && cipher_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
